/* rtl/hamming_stream_decoder_top_macros.svh */
// Assertion macros for the Hamming stream decoder.
`ifndef HAMMING_STREAM_DECODER_TOP_MACROS_SVH
`define HAMMING_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define HSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hsd_pkg.sv */
// Shared types and constants for the Hamming stream decoder.
`timescale 1ns / 1ps
package hsd_pkg;

   localparam int BYTE_W       = 1 << 3;
   localparam int BIT_CNT_W    = 4;
   localparam int RESULT_LIMIT = 8;
   localparam int RES_CNT_W    = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_FLUSH
   } hsd_state_type;

   typedef struct packed {
      logic clear;
      logic fill_en;
      logic fill_bit;
      logic drain_en;
   } blk_ctrl_type;

   typedef struct packed {
      logic last_slot;
      logic drain_bit;
      logic drain_data;
      logic drain_last;
      logic fixed;
   } blk_stat_type;

   typedef struct packed {
      logic clear;
      logic step_start;
      logic bit_req;
      logic bit_val;
      logic fixed;
      logic flush;
   } pkr_ctrl_type;

   typedef struct packed {
      logic stall;
      logic flush_done;
      logic pend_valid;
   } pkr_stat_type;

endpackage

/* rtl/hsd_channels.sv */
// Handshake channel interfaces: coded input, decoded output, register write.
`timescale 1ns / 1ps
interface hsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] coded_byte;
   logic       stream_start;

   modport source (output valid, output coded_byte, output stream_start, input ready);
   modport sink   (input valid, input coded_byte, input stream_start, output ready);
endinterface

interface hsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       was_corrected;
   logic       last_of_run;

   modport source (output valid, output data_byte, output was_corrected,
                   output last_of_run, input ready);
   modport sink   (input valid, input data_byte, input was_corrected,
                   input last_of_run, output ready);
endinterface

interface hsd_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] parity_count;

   modport source (output valid, output parity_count, input ready);
   modport sink   (input valid, input parity_count, output ready);
endinterface

/* rtl/hsd_block_buf.sv */
// Block shift register with running syndrome and corrected serial read-out.
`timescale 1ns / 1ps
module hsd_block_buf #(
   parameter int MAX_PARITY_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [MAX_PARITY_BITS-1:0] block_len,
   input  hsd_pkg::blk_ctrl_type      ctrl,
   output hsd_pkg::blk_stat_type      stat
);
   import hsd_pkg::*;

   localparam int PW    = MAX_PARITY_BITS;
   localparam int BLK_W = (1 << PW) - 1;

   logic [BLK_W-1:0] bits_ff, bits_in;
   logic [PW-1:0]    fill_ff, fill_in;
   logic [PW-1:0]    syn_ff, syn_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    len_m1;
   logic [PW-1:0]    fill_pos;
   logic             fix_en;

   assign len_m1   = block_len - PW'(1);
   assign fill_pos = fill_ff + PW'(1);
   // syndrome naming a parity position leaves the data alone
   assign fix_en   = (syn_ff != '0) && ((syn_ff & (syn_ff - PW'(1))) != '0);

   always_comb begin
      stat.last_slot  = (fill_ff == len_m1);
      stat.drain_bit  = bits_ff[0] ^ (fix_en && (pos_ff == syn_ff));
      stat.drain_data = ((pos_ff & (pos_ff - PW'(1))) != '0);
      stat.drain_last = (pos_ff == block_len);
      stat.fixed      = fix_en;
   end

   always_comb begin
      bits_in = bits_ff;
      fill_in = fill_ff;
      syn_in  = syn_ff;
      pos_in  = pos_ff;
      if (ctrl.clear) begin
         fill_in = '0;
         syn_in  = '0;
      end else if (ctrl.fill_en) begin
         // new bit lands at the top of the live block so the first bit ends at 0
         bits_in         = {1'b0, bits_ff[BLK_W-1:1]};
         bits_in[len_m1] = ctrl.fill_bit;
         // syndrome is the XOR of the positions of all set bits
         syn_in = syn_ff ^ (ctrl.fill_bit ? fill_pos : '0);
         if (fill_ff == len_m1) begin
            fill_in = '0;
            pos_in  = PW'(1);
         end else begin
            fill_in = fill_pos;
         end
      end else if (ctrl.drain_en) begin
         bits_in = {1'b0, bits_ff[BLK_W-1:1]};
         if (pos_ff == block_len) begin
            syn_in = '0;
            pos_in = PW'(1);
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         syn_ff  <= '0;
         pos_ff  <= PW'(1);
      end else begin
         fill_ff <= fill_in;
         syn_ff  <= syn_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
   end

endmodule

/* rtl/hsd_byte_pack.sv */
// Packs data bits into bytes, parks the newest byte and drives the output register.
`timescale 1ns / 1ps
module hsd_byte_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  hsd_pkg::pkr_ctrl_type ctrl,
   output hsd_pkg::pkr_stat_type stat,
   hsd_rsp_if.source             rsp
);
   import hsd_pkg::*;

   logic [BYTE_W-1:0]    acc_ff, acc_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0]    pend_byte_ff, pend_byte_in;
   logic                 pend_fix_ff, pend_fix_in;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_fix_ff, out_fix_in;
   logic                 out_last_ff, out_last_in;

   logic              out_free;
   logic              completes;
   logic              room;
   logic              take;
   logic [BYTE_W-1:0] new_byte;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign completes = ctrl.bit_req && (cnt_ff == 3'(BYTE_W - 1));
   assign room      = (res_cnt_ff < RES_CNT_W'(RESULT_LIMIT));
   assign new_byte  = {ctrl.bit_val, acc_ff[BYTE_W-1:1]};

   // a finished byte only waits when the parked one cannot move on
   always_comb begin
      stat.stall      = completes && room && pend_valid_ff && !out_free;
      stat.flush_done = !pend_valid_ff || out_free;
      stat.pend_valid = pend_valid_ff;
   end

   assign take = ctrl.bit_req && !stat.stall;

   always_comb begin
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_fix_in   = pend_fix_ff;
      res_cnt_in    = res_cnt_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_fix_in    = out_fix_ff;
      out_last_in   = out_last_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (ctrl.clear) begin
         cnt_in = '0;
      end
      if (ctrl.step_start) begin
         res_cnt_in = '0;
      end

      if (take) begin
         acc_in = new_byte;
         cnt_in = cnt_ff + 3'd1;
         // bytes past the per-beat limit are dropped
         if (completes && room) begin
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_byte_in  = pend_byte_ff;
               out_fix_in   = pend_fix_ff;
               out_last_in  = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_byte_in  = new_byte;
            pend_fix_in   = ctrl.fixed;
            res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
         end
      end else if (ctrl.flush && pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_byte_in   = pend_byte_ff;
         out_fix_in    = pend_fix_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         res_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         res_cnt_ff    <= res_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      pend_byte_ff <= pend_byte_in;
      pend_fix_ff  <= pend_fix_in;
      out_byte_ff  <= out_byte_in;
      out_fix_ff   <= out_fix_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.data_byte     = out_byte_ff;
   assign rsp.was_corrected = out_fix_ff;
   assign rsp.last_of_run   = out_last_ff;

endmodule

/* rtl/hamming_stream_decoder_top.sv */
// Top level of the Hamming stream decoder: bit sequencer and register.
//
//   port    dir  payload                                   handshake
//   req_ch  in   coded_byte[7:0], stream_start             valid/ready
//   rsp_ch  out  data_byte[7:0], was_corrected, last_of_run valid/ready
//   csr_ch  in   parity_count[2:0]                         valid/ready
//
// One coded beat is taken in IDLE, then its bits enter the block one per cycle, pausing while a full block drains.
// A full block of 2^r-1 bits is read out one bit per cycle unless the packer stalls, corrected on the fly.
// Reset is synchronous; parity_count comes up as 3, all fill counts at zero.
// A stalled rsp_ch only holds the read-out when a second byte is ready to park.
`timescale 1ns / 1ps
`include "hamming_stream_decoder_top_macros.svh"
module hamming_stream_decoder_top #(
   parameter int MAX_PARITY_BITS = 6
) (
   input  logic      clock,
   input  logic      reset,
   hsd_req_if.sink   req_ch,
   hsd_rsp_if.source rsp_ch,
   hsd_csr_if.sink   csr_ch
);
   import hsd_pkg::*;

   localparam int PW  = MAX_PARITY_BITS;
   localparam int RW  = 4;

   hsd_state_type        state_ff, state_in;
   logic [BYTE_W-1:0]    in_bits_ff, in_bits_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [2:0]           parity_count_ff, parity_count_in;

   logic          req_take;
   logic          csr_take;
   logic [RW-1:0] r_eff;
   logic [PW-1:0] block_len;

   blk_ctrl_type blk_ctrl;
   blk_stat_type blk_stat;
   pkr_ctrl_type pkr_ctrl;
   pkr_stat_type pkr_stat;

   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid && csr_ch.ready;

   // out-of-range parity counts are pinned to the supported span
   always_comb begin
      if (parity_count_ff < 3'd2) begin
         r_eff = RW'(2);
      end else if (32'(parity_count_ff) > MAX_PARITY_BITS) begin
         r_eff = RW'(MAX_PARITY_BITS);
      end else begin
         r_eff = RW'(parity_count_ff);
      end
      block_len = PW'((32'd1 << r_eff) - 32'd1);
   end

   hsd_block_buf #(
      .MAX_PARITY_BITS (MAX_PARITY_BITS)
   ) u_block (
      .clock     (clock),
      .reset     (reset),
      .block_len (block_len),
      .ctrl      (blk_ctrl),
      .stat      (blk_stat)
   );

   hsd_byte_pack u_pack (
      .clock (clock),
      .reset (reset),
      .ctrl  (pkr_ctrl),
      .stat  (pkr_stat),
      .rsp   (rsp_ch)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (blk_stat.last_slot) begin
               state_in = ST_DRAIN;
            end else if (bit_cnt_ff == BIT_CNT_W'(BYTE_W - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_DRAIN: begin
            if (!pkr_stat.stall && blk_stat.drain_last) begin
               state_in = (bit_cnt_ff == BIT_CNT_W'(BYTE_W)) ? ST_FLUSH : ST_FILL;
            end
         end
         ST_FLUSH: begin
            if (pkr_stat.flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready        = 1'b0;
      csr_ch.ready        = 1'b0;
      blk_ctrl.clear      = (req_take && req_ch.stream_start) || csr_take;
      blk_ctrl.fill_en    = 1'b0;
      blk_ctrl.fill_bit   = in_bits_ff[0];
      blk_ctrl.drain_en   = 1'b0;
      pkr_ctrl.clear      = req_take && req_ch.stream_start;
      pkr_ctrl.step_start = req_take;
      pkr_ctrl.bit_req    = 1'b0;
      pkr_ctrl.bit_val    = blk_stat.drain_bit;
      pkr_ctrl.fixed      = blk_stat.fixed;
      pkr_ctrl.flush      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            csr_ch.ready = 1'b1;
         end
         ST_FILL: begin
            blk_ctrl.fill_en = 1'b1;
         end
         ST_DRAIN: begin
            pkr_ctrl.bit_req  = blk_stat.drain_data;
            blk_ctrl.drain_en = !pkr_stat.stall;
         end
         ST_FLUSH: begin
            pkr_ctrl.flush = 1'b1;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      in_bits_in      = in_bits_ff;
      bit_cnt_in      = bit_cnt_ff;
      parity_count_in = parity_count_ff;
      if (req_take) begin
         in_bits_in = req_ch.coded_byte;
         bit_cnt_in = '0;
      end else if (blk_ctrl.fill_en) begin
         in_bits_in = {1'b0, in_bits_ff[BYTE_W-1:1]};
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      end
      if (csr_take) begin
         parity_count_in = csr_ch.parity_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         bit_cnt_ff      <= '0;
         parity_count_ff <= 3'd3;
      end else begin
         state_ff        <= state_in;
         bit_cnt_ff      <= bit_cnt_in;
         parity_count_ff <= parity_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_bits_ff <= in_bits_in;
   end

   `HSD_ASSERT_IMP(a_idle_nothing_parked, clock, reset, state_ff == ST_IDLE, !pkr_stat.pend_valid, "byte still parked while idle")
   `HSD_ASSERT_NXT(a_beat_starts_fill, clock, reset, req_take, (state_ff == ST_FILL) && (bit_cnt_ff == '0), "accepted beat did not start at bit zero")
   `HSD_ASSERT_IMP(a_drain_after_bit, clock, reset, state_ff == ST_DRAIN, bit_cnt_ff != '0, "block read-out without a consumed bit")

endmodule
